[hdl/slc_pkg.sv]
// ----------------------------------------------------------------------------
// slc_pkg
// Shared widths, language mode codes and character codes for the source
// line classifier.
// ----------------------------------------------------------------------------
package slc_pkg;

  // payload widths
  localparam int BYTE_WIDTH    = 8;
  localparam int OUT_WIDTH     = 32;
  localparam int MODE_WIDTH    = 2;
  localparam int COUNT_WIDTH_DEF = 32;

  // language mode codes
  localparam logic [MODE_WIDTH-1:0] MODE_C       = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_ROFF    = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_GENERIC = 2'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_RESET   = MODE_GENERIC;

  // character codes
  localparam logic [BYTE_WIDTH-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_WIDTH-1:0] CH_BSP    = 8'h08;
  localparam logic [BYTE_WIDTH-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_WIDTH-1:0] CH_NL     = 8'h0a;
  localparam logic [BYTE_WIDTH-1:0] CH_VT     = 8'h0b;
  localparam logic [BYTE_WIDTH-1:0] CH_FF     = 8'h0c;
  localparam logic [BYTE_WIDTH-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_WIDTH-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_WIDTH-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_WIDTH-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_WIDTH-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_WIDTH-1:0] CH_STAR   = 8'h2a;
  localparam logic [BYTE_WIDTH-1:0] CH_DOT    = 8'h2e;
  localparam logic [BYTE_WIDTH-1:0] CH_SLASH  = 8'h2f;
  localparam logic [BYTE_WIDTH-1:0] CH_BSLASH = 8'h5c;

endpackage

[hdl/slc_ifs.sv]
// ----------------------------------------------------------------------------
// slc channel interfaces
// Valid/ready channels for the byte stream and for the per-file totals.
// ----------------------------------------------------------------------------

// byte stream channel
interface slc_byte_if import slc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BYTE_WIDTH-1:0] byte_value;
  logic                  end_of_file;

  modport source (output valid, byte_value, end_of_file, input ready);
  modport sink   (input valid, byte_value, end_of_file, output ready);
endinterface

// per-file totals channel
interface slc_result_if import slc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_WIDTH-1:0] total_lines;
  logic [OUT_WIDTH-1:0] code_line_count;
  logic [OUT_WIDTH-1:0] comment_line_count;
  logic [OUT_WIDTH-1:0] blank_line_count;
  logic [OUT_WIDTH-1:0] byte_length;
  logic                 is_binary;

  modport source (output valid, total_lines, code_line_count, comment_line_count,
                  blank_line_count, byte_length, is_binary, input ready);
  modport sink   (input valid, total_lines, code_line_count, comment_line_count,
                  blank_line_count, byte_length, is_binary, output ready);
endinterface

[hdl/source_line_classifier.sv]
// ----------------------------------------------------------------------------
// source_line_classifier
// Sorts the lines of a byte stream into code, comment and blank lines and
// reports the totals, with the byte count and a binary flag, per file.
// ----------------------------------------------------------------------------
// Throughput: one byte transfer per cycle; the scanner state advances once
// per byte through one input register and one result register.
// The totals are registered when the end-of-file item leaves the input
// register. An end-of-file item waits in the input register while a previous
// result is still held. Reset (rst, synchronous) clears all counters and
// line state and sets the language mode to generic.
module source_line_classifier import slc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [MODE_WIDTH-1:0] cfg_write_data,
  slc_byte_if.sink              bytes,
  slc_result_if.source          result
);

  localparam int EXT_WIDTH = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SLASH, ST_LINE_CMT, ST_BLOCK, ST_BLOCK_STAR, ST_STR, ST_STR_ESC,
    ST_CHR, ST_CHR_ESC, ST_ROFF_SP, ST_ROFF_BS
  } scan_state_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [OUT_WIDTH-1:0]   out_t;

  function automatic count_t sat_inc(count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

  function automatic out_t clamp_out(count_t v);
    logic [EXT_WIDTH-1:0] ext;
    ext = EXT_WIDTH'(v);
    return ((ext >> OUT_WIDTH) != '0) ? '1 : ext[OUT_WIDTH-1:0];
  endfunction

  function automatic logic is_space(logic [BYTE_WIDTH-1:0] b);
    return b == CH_SPACE || b == CH_BSP || b == CH_FF || b == CH_NL ||
           b == CH_CR || b == CH_TAB || b == CH_VT;
  endfunction

  // input register
  logic                  s1_valid;
  logic [BYTE_WIDTH-1:0] s1_byte;
  logic                  s1_eof;
  logic                  s1_adv;

  // scanner and counter state
  logic [MODE_WIDTH-1:0] language_mode;
  scan_state_t           scan_state, scan_state_next;
  logic                  code_flag, code_flag_next;
  logic                  cmt_flag, cmt_flag_next;
  logic [1:0]            line_pos, line_pos_next;
  count_t                code_acc, code_acc_next;
  count_t                cmt_acc, cmt_acc_next;
  count_t                blank_acc, blank_acc_next;
  count_t                length_acc, length_acc_next;
  logic                  binary_seen, binary_seen_next;

  // result register
  logic res_valid;
  out_t res_total, res_code, res_cmt, res_blank, res_length;
  logic res_binary;
  out_t total_next, code_out, cmt_out, blank_out, length_out;

  // helpers for the C idle rule
  scan_state_t idle_state;
  logic        idle_code;
  logic        slash_code;
  logic        close_code, close_cmt, do_close;

  // handshake
  assign s1_adv      = s1_valid && (!s1_eof || !res_valid || result.ready);
  assign bytes.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
    if (bytes.ready && bytes.valid) begin
      s1_byte <= bytes.byte_value;
      s1_eof  <= bytes.end_of_file;
    end
  end

  // C scanner: behavior between tokens
  always_comb begin
    idle_state = ST_IDLE;
    idle_code  = 1'b0;
    if (!is_space(s1_byte)) begin
      if (s1_byte == CH_SLASH) begin
        idle_state = ST_SLASH;
      end else begin
        idle_code = 1'b1;
        if (s1_byte == CH_DQUOTE) begin
          idle_state = ST_STR;
        end else if (s1_byte == CH_SQUOTE) begin
          idle_state = ST_CHR;
        end
      end
    end
  end

  // a lone slash counts as code
  assign slash_code = (language_mode == MODE_C) && (scan_state == ST_SLASH) &&
                      (s1_eof || (s1_byte != CH_SLASH && s1_byte != CH_STAR));
  assign close_code = code_flag | slash_code;
  assign close_cmt  = cmt_flag;
  assign do_close   = s1_eof ? (line_pos != 2'd0) : (s1_byte == CH_NL);

  // line accounting
  always_comb begin
    code_acc_next  = code_acc;
    cmt_acc_next   = cmt_acc;
    blank_acc_next = blank_acc;
    if (do_close) begin
      if (close_code) begin
        code_acc_next = sat_inc(code_acc);
      end else if (close_cmt) begin
        cmt_acc_next = sat_inc(cmt_acc);
      end else begin
        blank_acc_next = sat_inc(blank_acc);
      end
    end
  end

  // totals at end of file
  assign code_out   = clamp_out(code_acc_next);
  assign cmt_out    = clamp_out(cmt_acc_next);
  assign blank_out  = clamp_out(blank_acc_next);
  assign length_out = clamp_out(length_acc);

  always_comb begin
    logic [OUT_WIDTH+1:0] sum;
    sum = (OUT_WIDTH+2)'(code_out) + (OUT_WIDTH+2)'(cmt_out) + (OUT_WIDTH+2)'(blank_out);
    total_next = (sum[OUT_WIDTH+1:OUT_WIDTH] != 2'd0) ? '1 : sum[OUT_WIDTH-1:0];
  end

  // per-byte scanner step
  always_comb begin
    scan_state_next  = scan_state;
    code_flag_next   = close_code;
    cmt_flag_next    = cmt_flag;
    line_pos_next    = line_pos;
    length_acc_next  = sat_inc(length_acc);
    binary_seen_next = binary_seen;

    if (s1_byte == CH_NL) begin
      code_flag_next = 1'b0;
      cmt_flag_next  = 1'b0;
      line_pos_next  = 2'd0;
    end else begin
      if (s1_byte == CH_NUL) begin
        binary_seen_next = 1'b1;
      end
      if (line_pos != 2'd2) begin
        line_pos_next = line_pos + 2'd1;
      end
    end

    case (language_mode)
      MODE_C: begin
        case (scan_state)
          ST_SLASH: begin
            if (s1_byte == CH_SLASH) begin
              cmt_flag_next   = 1'b1;
              scan_state_next = ST_LINE_CMT;
            end else if (s1_byte == CH_STAR) begin
              cmt_flag_next   = 1'b1;
              scan_state_next = ST_BLOCK;
            end else begin
              scan_state_next = idle_state;
              code_flag_next  = code_flag_next | idle_code;
            end
          end
          ST_LINE_CMT: begin
            if (s1_byte == CH_NL) scan_state_next = ST_IDLE;
          end
          ST_BLOCK: begin
            if (s1_byte == CH_STAR) scan_state_next = ST_BLOCK_STAR;
            cmt_flag_next = 1'b1;
          end
          ST_BLOCK_STAR: begin
            if (s1_byte == CH_SLASH) begin
              scan_state_next = ST_IDLE;
            end else if (s1_byte != CH_STAR) begin
              scan_state_next = ST_BLOCK;
            end
            cmt_flag_next = 1'b1;
          end
          ST_STR, ST_CHR: begin
            if (s1_byte == CH_NL) begin
              scan_state_next = ST_IDLE;
            end else begin
              code_flag_next = 1'b1;
              if (s1_byte == ((scan_state == ST_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
                scan_state_next = ST_IDLE;
              end else if (s1_byte == CH_BSLASH) begin
                scan_state_next = (scan_state == ST_STR) ? ST_STR_ESC : ST_CHR_ESC;
              end
            end
          end
          ST_STR_ESC: begin
            code_flag_next  = 1'b1;
            scan_state_next = ST_STR;
          end
          ST_CHR_ESC: begin
            code_flag_next  = 1'b1;
            scan_state_next = ST_CHR;
          end
          default: begin
            scan_state_next = idle_state;
            code_flag_next  = code_flag_next | idle_code;
          end
        endcase
      end
      MODE_ROFF: begin
        case (scan_state)
          ST_ROFF_SP: begin
            if (s1_byte == CH_BSLASH) begin
              scan_state_next = ST_ROFF_BS;
            end else if (s1_byte != CH_SPACE && s1_byte != CH_TAB) begin
              scan_state_next = ST_IDLE;
            end
          end
          ST_ROFF_BS: begin
            if (s1_byte == CH_DQUOTE) begin
              code_flag_next  = 1'b0;
              cmt_flag_next   = 1'b1;
              scan_state_next = ST_LINE_CMT;
            end else begin
              scan_state_next = ST_IDLE;
            end
          end
          ST_LINE_CMT: begin
            if (s1_byte == CH_NL) scan_state_next = ST_IDLE;
          end
          default: begin
            scan_state_next = ST_IDLE;
            if (!is_space(s1_byte)) begin
              code_flag_next = 1'b1;
              if ((s1_byte == CH_DOT || s1_byte == CH_SQUOTE) && line_pos_next <= 2'd1) begin
                scan_state_next = ST_ROFF_SP;
              end
            end
          end
        endcase
      end
      default: begin
        // generic hash comments, also for the unused mode code
        scan_state_next = ST_IDLE;
        if (!is_space(s1_byte)) begin
          if (s1_byte == CH_HASH) begin
            cmt_flag_next = 1'b1;
          end else begin
            code_flag_next = 1'b1;
          end
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      language_mode <= MODE_RESET;
      scan_state    <= ST_IDLE;
      code_flag     <= 1'b0;
      cmt_flag      <= 1'b0;
      line_pos      <= 2'd0;
      code_acc      <= '0;
      cmt_acc       <= '0;
      blank_acc     <= '0;
      length_acc    <= '0;
      binary_seen   <= 1'b0;
    end else begin
      if (s1_adv) begin
        if (s1_eof) begin
          code_flag   <= 1'b0;
          cmt_flag    <= 1'b0;
          line_pos    <= 2'd0;
          code_acc    <= '0;
          cmt_acc     <= '0;
          blank_acc   <= '0;
          length_acc  <= '0;
          binary_seen <= 1'b0;
        end else begin
          code_flag   <= code_flag_next;
          cmt_flag    <= cmt_flag_next;
          line_pos    <= line_pos_next;
          code_acc    <= code_acc_next;
          cmt_acc     <= cmt_acc_next;
          blank_acc   <= blank_acc_next;
          length_acc  <= length_acc_next;
          binary_seen <= binary_seen_next;
        end
      end
      // mode write or end of file returns the scanner to idle
      if (cfg_write_en || (s1_adv && s1_eof)) begin
        scan_state <= ST_IDLE;
      end else if (s1_adv) begin
        scan_state <= scan_state_next;
      end
      if (cfg_write_en) begin
        language_mode <= cfg_write_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_eof) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (s1_adv && s1_eof) begin
      res_total  <= total_next;
      res_code   <= code_out;
      res_cmt    <= cmt_out;
      res_blank  <= blank_out;
      res_length <= length_out;
      res_binary <= binary_seen;
    end
  end

  assign result.valid              = res_valid;
  assign result.total_lines        = res_total;
  assign result.code_line_count    = res_code;
  assign result.comment_line_count = res_cmt;
  assign result.blank_line_count   = res_blank;
  assign result.byte_length        = res_length;
  assign result.is_binary          = res_binary;

endmodule
